### sv/lpme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpme_pkg: shared types and constants of the LSB pixel message embedder
// Store geometry, opcode and status codes, and the command that the front
// part hands to the back part through the queue.
// ----------------------------------------------------------------------------
package lpme_pkg;

    localparam int MSG_DEPTH = 256;                        // message store bytes
    localparam int ADDR_W    = $clog2(MSG_DEPTH);          // store address
    localparam int CNT_W     = $clog2(MSG_DEPTH + 1);      // stored byte count
    localparam int CUR_W     = $clog2(MSG_DEPTH * 8 + 3);  // bit cursor
    localparam int CMP_W     = CUR_W + 1;                  // cursor + 2 vs. total bits

    localparam int QDEPTH    = 4;                          // command queue depth
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_EMBED = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_PIXEL   = 3'd0,
        ST_STORED  = 3'd1,
        ST_NEWLINE = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4
    } t_status;

    typedef struct packed {
        t_status             status;
        logic                we;     // write wdata at addr
        logic [7:0]          wdata;
        logic [ADDR_W-1:0]   addr;   // write address, or byte of first pixel bit
        logic [2:0]          off;    // bit offset of first pixel bit, MSB first
        logic [2:0]          mask;   // bit k set: channel k takes a message bit
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
    } t_cmd;

endpackage
`default_nettype wire

### sv/lpme_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpme_if: valid/ready channels of the LSB pixel message embedder
// One interface for the input items and one for the result items.
// ----------------------------------------------------------------------------
interface lpme_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] message_byte;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, opcode, message_byte, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, opcode, message_byte, red_in, green_in, blue_in,
                    output ready);
endinterface

interface lpme_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [2:0] status;

    modport source (output valid, red_out, green_out, blue_out, status,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, status,
                    output ready);
endinterface
`default_nettype wire

### sv/lpme_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpme_front: item intake and classification
// Owns the byte count and bit cursor, decides each item's status and builds
// the command for the back part.
// ----------------------------------------------------------------------------
module lpme_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    lpme_in_if.sink            i_in,
    input  wire logic          i_full,
    output logic               o_push,
    output lpme_pkg::t_cmd     o_cmd
);
    import lpme_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    logic [CUR_W-1:0] r_cursor, n_cursor;
    logic             accept;
    logic [CMP_W-1:0] total_bits;
    logic [CMP_W-1:0] cur_ext;
    logic [2:0]       mask;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    assign total_bits = CMP_W'({r_count, 3'b000});
    assign cur_ext    = CMP_W'(r_cursor);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mask[k] = (cur_ext + CMP_W'(k)) < total_bits;
        end
    end

    always_comb begin
        n_count  = r_count;
        n_cursor = r_cursor;
        o_push   = 1'b0;
        o_cmd    = '0;
        o_cmd.status = ST_CLEARED;
        unique case (t_opcode'(i_in.opcode))
            OP_LOAD: begin
                o_push = accept;
                if (i_in.message_byte == NEWLINE_BYTE) begin
                    o_cmd.status = ST_NEWLINE;
                end else if (r_count >= CNT_W'(MSG_DEPTH)) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.status = ST_STORED;
                    o_cmd.we     = 1'b1;
                    o_cmd.wdata  = i_in.message_byte;
                    o_cmd.addr   = r_count[ADDR_W-1:0];
                    n_count      = r_count + CNT_W'(1);
                end
            end
            OP_EMBED: begin
                o_push       = accept;
                o_cmd.status = ST_PIXEL;
                o_cmd.addr   = r_cursor[ADDR_W+2:3];
                o_cmd.off    = r_cursor[2:0];
                o_cmd.mask   = mask;
                o_cmd.red    = i_in.red_in;
                o_cmd.green  = i_in.green_in;
                o_cmd.blue   = i_in.blue_in;
                // advance only while bits remain; past the end, hold
                if (cur_ext < total_bits) begin
                    n_cursor = r_cursor + CUR_W'(3);
                end
            end
            OP_CLEAR: begin
                o_push       = accept;
                o_cmd.status = ST_CLEARED;
                n_count      = '0;
                n_cursor     = '0;
            end
            default: begin
                // unused opcode: consume, no result
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
        end else if (accept) begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MSG_DEPTH))
        else $error("stored byte count beyond store depth");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cur_ext <= total_bits + CMP_W'(2))
        else $error("bit cursor ran past the loaded bits");

endmodule
`default_nettype wire

### sv/lpme_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpme_queue: command queue between front and back
// Small FIFO of commands so intake and execution stall independently.
// ----------------------------------------------------------------------------
module lpme_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  lpme_pkg::t_cmd     i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_vld,
    output lpme_pkg::t_cmd     o_cmd
);
    import lpme_pkg::*;

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full = r_cnt == QCNT_W'(QDEPTH);
    assign o_vld  = r_cnt != '0;
    assign o_cmd  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full command queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_vld))
        else $error("pop from empty command queue");

endmodule
`default_nettype wire

### sv/lpme_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpme_back: command execution and result register
// Writes message bytes, reads the two bytes a pixel may straddle, and merges
// the message bits into the channel LSBs.
// ----------------------------------------------------------------------------
module lpme_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_vld,
    input  lpme_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    lpme_out_if.source         o_out
);
    import lpme_pkg::*;

    logic [7:0]        r_store [MSG_DEPTH];
    logic              r_vld;
    t_cmd              r_cmd;
    logic [7:0]        r_rd0;
    logic [7:0]        r_rd1;
    logic [ADDR_W-1:0] addr_nxt;
    logic [2:0]        msg_bit;
    logic [3:0]        pos;

    assign o_pop    = i_cmd_vld && (!r_vld || o_out.ready);
    assign addr_nxt = i_cmd.addr + ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_pop) begin
            r_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_vld <= 1'b0;
        end
    end

    // store write and the two reads; payload holds while the result stalls
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_cmd.we) begin
                r_store[i_cmd.addr] <= i_cmd.wdata;
            end
            r_cmd <= i_cmd;
            r_rd0 <= r_store[i_cmd.addr];
            r_rd1 <= r_store[addr_nxt];
        end
    end

    always_comb begin
        pos = '0;
        for (int k = 0; k < 3; k++) begin
            pos = {1'b0, r_cmd.off} + 4'(k);
            // bit 7 is first; past the byte edge, continue in the next byte
            msg_bit[k] = r_cmd.mask[k] &&
                         (pos[3] ? r_rd1[~pos[2:0]] : r_rd0[~pos[2:0]]);
        end
    end

    assign o_out.valid     = r_vld;
    assign o_out.red_out   = {r_cmd.red[7:1],   msg_bit[0]};
    assign o_out.green_out = {r_cmd.green[7:1], msg_bit[1]};
    assign o_out.blue_out  = {r_cmd.blue[7:1],  msg_bit[2]};
    assign o_out.status    = r_cmd.status;

endmodule
`default_nettype wire

### sv/lsb_pixel_message_embed_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsb_pixel_message_embed_core: LSB message embedder for RGB pixel streams
// Loads message bytes and hides their bits in the channel LSBs of pixels.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item per handshake: opcode 0 loads message_byte (newline
//   is skipped, a byte past the 256-byte store is dropped and flagged), opcode
//   1 embeds the next three message bits, MSB first, into the red, green and
//   blue LSBs, opcode 2 clears the byte count and the cursor. Opcode 3 is consumed
//   and yields no result.
//   o_out returns one result item per meaningful item, in order: the pixel
//   channels (zero for non-pixel items) and a status code.
//   Path: an accepted item is written into the command queue, then popped into
//   the result register and presented from there. Throughput: one item per
//   cycle while the receiver takes results, limited by the single command issue
//   per cycle into the message store, which takes one write or one pair of reads.
//   Reset clears the byte count, the cursor, the queue and the result valid;
//   the store contents need no clearing since only loaded bytes are used.
//   When the receiver stalls, the result register holds, the four-entry
//   command queue fills, and i_in.ready falls only once the queue is full.
// ----------------------------------------------------------------------------
module lsb_pixel_message_embed_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lpme_in_if.sink    i_in,
    lpme_out_if.source o_out
);
    import lpme_pkg::*;

    // front to queue
    logic q_push;
    t_cmd q_in_cmd;
    logic q_full;

    // queue to back
    logic q_vld;
    logic q_pop;
    t_cmd q_out_cmd;

    // classify items, track count and cursor, issue commands
    lpme_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (q_in_cmd)
    );

    // decouple intake from execution
    lpme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_cmd   (q_out_cmd)
    );

    // access the store and present results
    lpme_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (q_vld),
        .i_cmd     (q_out_cmd),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

### tb/lsb_pixel_message_embed_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_pixel_message_embed_core_tb: self-checking bench of the LSB embedder
// Drives load, embed, clear and spare opcodes through the input channel with
// random gaps and result stalls. Predicts every result with a local copy of
// the message store, byte count and bit cursor, and checks each field in order.
// ----------------------------------------------------------------------------
module lsb_pixel_message_embed_core_tb;
    import lpme_pkg::*;

    localparam int   CLK_HALF      = 6;       // 12 ns clock period
    localparam int   RESET_CYCLES  = 8;
    localparam int   IDLE_PCT      = 9;       // chance of an idle cycle on each side
    localparam int   RANDOM_ITEMS  = 1400;
    localparam int   STEADY_FROM   = 400;     // window of result items with no idling
    localparam int   STEADY_TO     = 700;
    localparam int   FILL_BYTES    = 280;     // enough loads to overflow the store
    localparam int   STALL_LIMIT   = 2000;    // cycles with no handshake at all
    localparam int   TAIL_CYCLES   = 8;       // margin after the final drain

    localparam logic [1:0] OP_SPARE = 2'd3;   // opcode with no meaning, no result

    // one result item: channels and status code
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        t_status    status;
    } t_pix_result;

    // one row of the directed table; want is used only when typed is set
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        typed;
        t_pix_result want;
    } t_stim_row;

    localparam t_pix_result PREDICTED = '0;

    localparam int N_DIRECTED = 25;
    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        // clear right after reset, then embed with nothing loaded
        '{OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, ST_CLEARED}},
        '{OP_EMBED, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'hFE, 8'hFE, 8'hFE, ST_PIXEL}},
        '{OP_EMBED, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, ST_PIXEL}},
        // spare opcode: consumed, no result
        '{OP_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, PREDICTED},
        // newline skipped, then three bytes, a zero byte among them
        '{OP_LOAD, NEWLINE_BYTE, 8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, ST_NEWLINE}},
        '{OP_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'h00, 8'h00, 8'h00, ST_STORED}},
        '{OP_LOAD, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1, '{8'h00, 8'h00, 8'h00, ST_STORED}},
        '{OP_LOAD, 8'hA5, 8'h00, 8'hFF, 8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, ST_STORED}},
        // walk all 24 loaded bits
        '{OP_EMBED, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, PREDICTED},
        '{OP_EMBED, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0, PREDICTED},
        '{OP_EMBED, 8'h00, 8'h55, 8'hAA, 8'h0F, 1'b0, PREDICTED},
        '{OP_EMBED, 8'h00, 8'hF0, 8'h0F, 8'h81, 1'b0, PREDICTED},
        '{OP_EMBED, 8'h00, 8'h7E, 8'h81, 8'h00, 1'b0, PREDICTED},
        '{OP_EMBED, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0, PREDICTED},
        '{OP_EMBED, 8'h00, 8'h01, 8'hFE, 8'h80, 1'b0, PREDICTED},
        '{OP_EMBED, 8'h00, 8'hAA, 8'h55, 8'hC3, 1'b0, PREDICTED},
        // bits exhausted: every LSB cleared
        '{OP_EMBED, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'hFE, 8'hFE, 8'hFE, ST_PIXEL}},
        // load after embedding, resume at the held cursor, pad the partial pixel
        '{OP_LOAD, 8'h80, 8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, ST_STORED}},
        '{OP_EMBED, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, PREDICTED},
        '{OP_EMBED, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0, PREDICTED},
        '{OP_EMBED, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0, PREDICTED},
        '{OP_EMBED, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'hFE, 8'hFE, 8'hFE, ST_PIXEL}},
        '{OP_SPARE, NEWLINE_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, PREDICTED},
        // clear drops the message: the next pixel gets zero LSBs
        '{OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'h00, 8'h00, 8'h00, ST_CLEARED}},
        '{OP_EMBED, 8'h00, 8'h01, 8'h01, 8'h01, 1'b1, '{8'h00, 8'h00, 8'h00, ST_PIXEL}}
    };

    logic i_clk;
    logic i_rst_n;

    lpme_in_if  item_in ();
    lpme_out_if result_out ();

    lsb_pixel_message_embed_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_in),
        .o_out   (result_out)
    );

    // Local copy of the embedder state
    logic [7:0]       msg_mem [MSG_DEPTH];
    logic [CNT_W-1:0] msg_count;
    logic [CUR_W-1:0] bit_pos;

    t_pix_result pending_embed_results [$];
    int          mismatch_count;
    int          result_items;    // accepted input items that produce a result
    int          stall_cycles;
    bit          steady_run;      // suppress idling on both sides

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Bit idx of the loaded message, MSB of each byte first; zero past the end.
    function automatic logic msg_bit(input int unsigned idx);
        if (idx >= msg_count * 8) return 1'b0;
        return msg_mem[idx / 8][7 - (idx % 8)];
    endfunction

    // Advance the local state by one item; return 1 when it yields a result.
    function automatic bit predict_embed(input logic [1:0] op, input logic [7:0] data,
                                         input logic [7:0] red, green, blue,
                                         output t_pix_result res);
        int unsigned total_bits;
        res        = '0;
        total_bits = msg_count * 8;
        case (op)
            OP_LOAD: begin
                if (data == NEWLINE_BYTE) begin
                    res.status = ST_NEWLINE;
                end else if (msg_count >= MSG_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    msg_mem[msg_count[ADDR_W-1:0]] = data;
                    msg_count  = msg_count + 1'b1;
                    res.status = ST_STORED;
                end
                return 1'b1;
            end
            OP_EMBED: begin
                res.red    = {red[7:1],   msg_bit(bit_pos)};
                res.green  = {green[7:1], msg_bit(bit_pos + 1)};
                res.blue   = {blue[7:1],  msg_bit(bit_pos + 2)};
                // hold the cursor once it has passed the loaded bits
                if (bit_pos < total_bits) bit_pos = bit_pos + 3'd3;
                res.status = ST_PIXEL;
                return 1'b1;
            end
            OP_CLEAR: begin
                msg_count  = '0;
                bit_pos    = '0;
                res.status = ST_CLEARED;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_result();
        t_pix_result want;
        if (pending_embed_results.size() == 0) begin
            report_mismatch($sformatf("result item with nothing pending, status %0d",
                                      result_out.status));
            return;
        end
        want = pending_embed_results.pop_front();
        if (result_out.red_out !== want.red)
            report_mismatch($sformatf("red_out got %02h want %02h",
                                      result_out.red_out, want.red));
        if (result_out.green_out !== want.green)
            report_mismatch($sformatf("green_out got %02h want %02h",
                                      result_out.green_out, want.green));
        if (result_out.blue_out !== want.blue)
            report_mismatch($sformatf("blue_out got %02h want %02h",
                                      result_out.blue_out, want.blue));
        if (result_out.status !== want.status)
            report_mismatch($sformatf("status got %0d want %s",
                                      result_out.status, want.status.name()));
    endtask

    // Result side: check each accepted item, then stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_out.ready <= 1'b0;
        end else begin
            if (result_out.valid === 1'b1 && result_out.ready === 1'b1) check_result();
            result_out.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_in.valid === 1'b1 && item_in.ready === 1'b1)
                     || (result_out.valid === 1'b1 && result_out.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles, %0d results pending", $realtime,
                     STALL_LIMIT, pending_embed_results.size());
            $display("lsb_pixel_message_embed_core_tb failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Present one item after an optional gap, hold it until accepted, then
    // advance the predictor. Call and return at a rising edge.
    task automatic send_item(input logic [1:0] op, input logic [7:0] data,
                             input logic [7:0] red, green, blue,
                             input bit typed, input t_pix_result typed_want);
        t_pix_result want;
        while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            item_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_in.valid        <= 1'b1;
        item_in.opcode       <= op;
        item_in.message_byte <= data;
        item_in.red_in       <= red;
        item_in.green_in     <= green;
        item_in.blue_in      <= blue;
        @(posedge i_clk);
        while (item_in.ready !== 1'b1) @(posedge i_clk);
        if (predict_embed(op, data, red, green, blue, want)) begin
            pending_embed_results.push_back(typed ? typed_want : want);
            result_items++;
            steady_run = (result_items >= STEADY_FROM) && (result_items < STEADY_TO);
        end
    endtask

    task automatic send_random(input logic [1:0] op, input logic [7:0] data);
        send_item(op, data, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 1'b0, PREDICTED);
    endtask

    // Occasionally slip in an item of any opcode with random fields.
    task automatic maybe_noise();
        if ($urandom_range(19) == 0)
            send_random(2'($urandom_range(3)), 8'($urandom_range(255)));
    endtask

    // Random message byte, with a newline now and then.
    function automatic logic [7:0] random_byte();
        return ($urandom_range(19) == 0) ? NEWLINE_BYTE : 8'($urandom_range(255));
    endfunction

    // Hold the input idle until every pending result has come back.
    task automatic drain_results();
        item_in.valid <= 1'b0;
        while (pending_embed_results.size() != 0) @(posedge i_clk);
    endtask

    // Clear (usually), load a message, then stream enough pixels to reach its
    // end, sometimes past it, with stray loads mixed into the pixel stream.
    task automatic message_round(input int unsigned n_bytes);
        int remaining_bits;
        int n_pix;
        if ($urandom_range(4) != 0) send_random(OP_CLEAR, 8'($urandom_range(255)));
        for (int k = 0; k < n_bytes; k++) begin
            maybe_noise();
            send_random(OP_LOAD, random_byte());
        end
        remaining_bits = int'(msg_count) * 8 - int'(bit_pos);
        if (remaining_bits < 0) remaining_bits = 0;
        n_pix = (remaining_bits + 2) / 3 + $urandom_range(3);
        for (int k = 0; k < n_pix; k++) begin
            maybe_noise();
            if ($urandom_range(24) == 0) send_random(OP_LOAD, random_byte());
            send_random(OP_EMBED, 8'($urandom_range(255)));
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        item_in.valid         = 1'b0;
        item_in.opcode        = OP_LOAD;
        item_in.message_byte  = 8'h00;
        item_in.red_in        = 8'h00;
        item_in.green_in      = 8'h00;
        item_in.blue_in       = 8'h00;
        result_items          = 0;
        steady_run            = 1'b0;
        msg_count             = '0;
        bit_pos               = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].red,
                      DIRECTED_ROWS[r].green, DIRECTED_ROWS[r].blue,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        end
        drain_results();

        // First round fills the store past capacity and walks every stored bit
        message_round(FILL_BYTES);

        // Short messages, with the occasional longer one and full drains
        while (result_items < N_DIRECTED + RANDOM_ITEMS) begin
            if ($urandom_range(3) == 0) drain_results();
            message_round(($urandom_range(14) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(0, 12));
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("lsb_pixel_message_embed_core_tb passed");
        end else begin
            $display("lsb_pixel_message_embed_core_tb failed");
        end
        $finish;
    end

endmodule

### lsb_pixel_message_embed_core.f
sv/lpme_pkg.sv
sv/lpme_if.sv
sv/lpme_front.sv
sv/lpme_queue.sv
sv/lpme_back.sv
sv/lsb_pixel_message_embed_core.sv
tb/lsb_pixel_message_embed_core_tb.sv
